// ----- hdl/optical_flow_dead_reckoning_top_assert.svh -----
// Assertion macros shared by the dead reckoning RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef OPTICAL_FLOW_DEAD_RECKONING_TOP_ASSERT_SVH
`define OPTICAL_FLOW_DEAD_RECKONING_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define OFDR_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define OFDR_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/ofdr_pkg.sv -----
// Shared types and constants for the optical flow dead reckoning block.
// No dependencies; used by ofdr_cordic and the top level.
`default_nettype none

package ofdr_pkg;

  localparam int OUT_W       = 48;  // result field width
  localparam int HEAD_W      = 32;  // binary angle width
  localparam int MMC_W       = 16;  // mm_per_count width
  localparam int APC_W       = 24;  // angle_per_count width
  localparam int CNT_W       = 8;   // sensor count width
  localparam int DMM_W       = 24;  // counts times mm_per_count, Q16 mm
  localparam int CV_W        = 40;  // CORDIC vector width, Q30 mm
  localparam int CZ_W        = 34;  // CORDIC residual angle width
  localparam int RES_W       = 26;  // rotated step rounded to Q16 mm
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 24;
  localparam int ATAN_ENTRIES = 24;
  localparam int ATAN_IDX_W  = 5;

  localparam logic [CFG_ADDR_W-1:0] CFG_MM_PER_COUNT    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ANGLE_PER_COUNT = 2'd1;

  // input op codes
  localparam logic OP_MOVE  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [MMC_W-1:0] MMC_RESET = 16'd13240;
  localparam logic [APC_W-1:0] APC_RESET = 24'd1046168;

  // CORDIC gain compensation, 0.6072529350 in Q30
  localparam logic signed [30:0] GAIN_Q30 = 31'sd652032874;

  // atan(2^-i) in binary angle units, full turn is 2^32
  localparam logic [31:0] ATAN_TAB [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct packed {
    logic busy;
    logic done;
  } ofdr_rot_sts_t;

endpackage

`default_nettype wire

// ----- hdl/optical_flow_dead_reckoning_top.sv -----
// Top level of the optical flow dead reckoning block.
// Depends on ofdr_pkg, ofdr_cordic and the assertion macro header.
`default_nettype none
`include "optical_flow_dead_reckoning_top_assert.svh"

// One beat in, one beat out. A motion sample (op 0) turns the heading by
// dx_count * angle_per_count, adds the scaled counts to the path totals and
// moves x/y along the mid-turn heading through an iterative CORDIC.
// A motion sample waits on the CORDIC, which does one micro-rotation
// per cycle; a clear (op 1) skips the CORDIC and zeroes the path totals.
// The result sits in an output register, so the next sample is taken
// while it waits for out_ready.
// Position and path totals saturate at the signed POS_WIDTH bounds and are
// shown as their low 48 bits. Write configuration only while idle.
module optical_flow_dead_reckoning_top
  import ofdr_pkg::*;
#(
  parameter int CORDIC_STEPS = 16,
  parameter int POS_WIDTH    = 48
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    in_op,
  input  wire logic signed [CNT_W-1:0] in_dx_count,
  input  wire logic signed [CNT_W-1:0] in_dy_count,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [OUT_W-1:0]      out_x_pos,
  output logic signed [OUT_W-1:0]      out_y_pos,
  output logic [HEAD_W-1:0]            out_heading_out,
  output logic signed [OUT_W-1:0]      out_path_x,
  output logic signed [OUT_W-1:0]      out_path_y
);

  localparam logic signed [POS_WIDTH-1:0] POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
  localparam logic signed [POS_WIDTH-1:0] POS_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PREP = 5'b00010,
    S_HEAD = 5'b00100,
    S_ROT  = 5'b01000,
    S_POS  = 5'b10000
  } state_t;

  // output hand-off is folded into S_IDLE's predecessor via a flag
  state_t                     state_r;
  logic                       out_pend_r;
  logic [MMC_W-1:0]           mm_r;
  logic [APC_W-1:0]           apc_r;
  logic                       op_r;
  logic signed [CNT_W-1:0]    dx_r;
  logic signed [CNT_W-1:0]    dy_r;
  logic signed [DMM_W-1:0]    dmx_r;
  logic signed [DMM_W-1:0]    dmy_r;
  logic [HEAD_W-1:0]          delta_r;
  logic [HEAD_W-1:0]          heading_r;
  logic signed [POS_WIDTH-1:0] pos_x_r;
  logic signed [POS_WIDTH-1:0] pos_y_r;
  logic signed [POS_WIDTH-1:0] sum_x_r;
  logic signed [POS_WIDTH-1:0] sum_y_r;
  logic                       out_valid_r;

  logic signed [DMM_W:0]      dmx_full;
  logic signed [DMM_W:0]      dmy_full;
  logic signed [HEAD_W:0]     delta_full;
  logic [HEAD_W-1:0]          mid;
  logic                       rot_start;
  ofdr_rot_sts_t              rot_sts;
  logic signed [RES_W-1:0]    rot_x;
  logic signed [RES_W-1:0]    rot_y;
  logic                       in_fire;
  logic                       out_load;

  function automatic logic signed [POS_WIDTH-1:0] sat_add(
    input logic signed [POS_WIDTH-1:0] a,
    input logic signed [POS_WIDTH-1:0] b
  );
    logic signed [POS_WIDTH:0] s;
    s = {a[POS_WIDTH-1], a} + {b[POS_WIDTH-1], b};
    if (s[POS_WIDTH] != s[POS_WIDTH-1]) begin
      return s[POS_WIDTH] ? POS_MIN : POS_MAX;
    end
    return s[POS_WIDTH-1:0];
  endfunction

  assign in_ready = (state_r == S_IDLE) && !out_pend_r;
  assign in_fire  = in_valid && in_ready;
  // push a finished result once the output register is free
  assign out_load = out_pend_r && (!out_valid_r || out_ready);

  always_comb begin
    dmx_full   = (DMM_W+1)'(dx_r) * (DMM_W+1)'($signed({1'b0, mm_r}));
    dmy_full   = (DMM_W+1)'(dy_r) * (DMM_W+1)'($signed({1'b0, mm_r}));
    delta_full = (HEAD_W+1)'(dx_r) * (HEAD_W+1)'($signed({1'b0, apc_r}));
    // heading at mid-turn: floor half of the signed delta
    mid        = heading_r + {delta_r[HEAD_W-1], delta_r[HEAD_W-1:1]};
    rot_start  = (state_r == S_HEAD);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mm_r  <= MMC_RESET;
      apc_r <= APC_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_MM_PER_COUNT:    mm_r  <= cfg_wdata[MMC_W-1:0];
        CFG_ANGLE_PER_COUNT: apc_r <= cfg_wdata[APC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      out_pend_r <= 1'b0;
      heading_r  <= '0;
      pos_x_r    <= '0;
      pos_y_r    <= '0;
      sum_x_r    <= '0;
      sum_y_r    <= '0;
    end else begin
      if (out_load) begin
        out_pend_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            op_r    <= in_op;
            dx_r    <= in_dx_count;
            dy_r    <= in_dy_count;
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          if (op_r == OP_CLEAR) begin
            sum_x_r    <= '0;
            sum_y_r    <= '0;
            out_pend_r <= 1'b1;
            state_r    <= S_IDLE;
          end else begin
            dmx_r   <= dmx_full[DMM_W-1:0];
            dmy_r   <= dmy_full[DMM_W-1:0];
            delta_r <= delta_full[HEAD_W-1:0];
            state_r <= S_HEAD;
          end
        end
        S_HEAD: begin
          sum_x_r   <= sat_add(sum_x_r, POS_WIDTH'(dmx_r));
          sum_y_r   <= sat_add(sum_y_r, POS_WIDTH'(dmy_r));
          heading_r <= heading_r + delta_r;
          state_r   <= S_ROT;
        end
        S_ROT: begin
          if (rot_sts.done) begin
            state_r <= S_POS;
          end
        end
        S_POS: begin
          pos_x_r    <= sat_add(pos_x_r, POS_WIDTH'(rot_x));
          pos_y_r    <= sat_add(pos_y_r, POS_WIDTH'(rot_y));
          out_pend_r <= 1'b1;
          state_r    <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // output register: hold until taken
  logic signed [63:0] pos_x_ext;
  logic signed [63:0] pos_y_ext;
  logic signed [63:0] sum_x_ext;
  logic signed [63:0] sum_y_ext;

  always_comb begin
    pos_x_ext = 64'(pos_x_r);
    pos_y_ext = 64'(pos_y_r);
    sum_x_ext = 64'(sum_x_r);
    sum_y_ext = 64'(sum_y_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x_pos       <= pos_x_ext[OUT_W-1:0];
      out_y_pos       <= pos_y_ext[OUT_W-1:0];
      out_heading_out <= heading_r;
      out_path_x      <= sum_x_ext[OUT_W-1:0];
      out_path_y      <= sum_y_ext[OUT_W-1:0];
    end
  end

  assign out_valid = out_valid_r;

  ofdr_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rot_start),
    .dmy   (dmy_r),
    .angle (mid),
    .sts   (rot_sts),
    .rot_x (rot_x),
    .rot_y (rot_y)
  );

  `OFDR_ASSERT_NXT(a_accept_to_prep, in_fire, state_r == S_PREP, "accepted beat did not start work")
  `OFDR_ASSERT_IMP(a_done_in_rot, rot_sts.done, state_r == S_ROT, "rotator finished outside wait")
  `OFDR_ASSERT_NXT(a_heading_hold, state_r != S_HEAD, $stable(heading_r), "heading moved outside update")
  `OFDR_ASSERT_IMP(a_rot_idle_at_pos, state_r == S_POS, !rot_sts.busy, "rotator busy at position add")
  `OFDR_ASSERT_NXT(a_load_shows, out_load, out_valid_r && !out_pend_r, "result not moved to output")

endmodule

`default_nettype wire

// ----- hdl/ofdr_cordic.sv -----
// Iterative CORDIC rotator: turns a forward distance by a binary angle.
// One shared shift/add unit runs one micro-rotation per cycle. Uses ofdr_pkg.
`default_nettype none
`include "optical_flow_dead_reckoning_top_assert.svh"

module ofdr_cordic
  import ofdr_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic signed [DMM_W-1:0]  dmy,
  input  wire logic [HEAD_W-1:0]        angle,
  output ofdr_rot_sts_t                 sts,
  output logic signed [RES_W-1:0]       rot_x,
  output logic signed [RES_W-1:0]       rot_y
);

  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  typedef enum logic [3:0] {
    C_IDLE  = 4'b0001,
    C_MUL   = 4'b0010,
    C_ITER  = 4'b0100,
    C_ROUND = 4'b1000
  } cstate_t;

  cstate_t                  state_r;
  logic [STEP_W-1:0]        step_r;
  logic signed [54:0]       prod_r;
  logic                     fold_r;
  logic signed [CV_W-1:0]   x_r;
  logic signed [CV_W-1:0]   y_r;
  logic signed [CZ_W-1:0]   z_r;
  logic                     done_r;

  logic signed [54:0]       gprod;
  logic signed [CV_W-1:0]   gx;
  logic                     fold;
  logic [HEAD_W-1:0]        ang_fold;
  logic signed [CV_W-1:0]   xs;
  logic signed [CV_W-1:0]   ys;
  logic signed [CZ_W-1:0]   atan_z;
  logic signed [CV_W-1:0]   x_rnd;
  logic signed [CV_W-1:0]   y_rnd;

  always_comb begin
    gprod    = 55'(dmy) * 55'(GAIN_Q30);
    gx       = {prod_r[54], prod_r[54:16]};
    // second and third quadrants: negate the vector, rotate by a half turn
    fold     = angle[31] ^ angle[30];
    ang_fold = {angle[31] ^ fold, angle[30:0]};
    xs       = x_r >>> step_r;
    ys       = y_r >>> step_r;
    atan_z   = $signed({2'b00, ATAN_TAB[ATAN_IDX_W'(step_r)]});
    x_rnd    = x_r + 40'sd8192;
    y_rnd    = y_r + 40'sd8192;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        C_IDLE: begin
          if (start) begin
            prod_r  <= gprod;
            fold_r  <= fold;
            z_r     <= CZ_W'($signed(ang_fold));
            state_r <= C_MUL;
          end
        end
        C_MUL: begin
          x_r     <= fold_r ? -gx : gx;
          y_r     <= '0;
          step_r  <= '0;
          state_r <= C_ITER;
        end
        C_ITER: begin
          if (!z_r[CZ_W-1]) begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - atan_z;
          end else begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + atan_z;
          end
          step_r <= step_r + 1'b1;
          if (step_r == LAST_STEP) begin
            state_r <= C_ROUND;
          end
        end
        C_ROUND: begin
          // round Q30 back to Q16
          rot_x   <= x_rnd[RES_W+13:14];
          rot_y   <= y_rnd[RES_W+13:14];
          done_r  <= 1'b1;
          state_r <= C_IDLE;
        end
        default: begin
          state_r <= C_IDLE;
        end
      endcase
    end
  end

  assign sts.busy = (state_r != C_IDLE);
  assign sts.done = done_r;

  `OFDR_ASSERT_IMP(a_start_when_idle, start, state_r == C_IDLE, "CORDIC started while busy")
  `OFDR_ASSERT_NXT(a_last_step_rounds, state_r == C_ITER && step_r == LAST_STEP, state_r == C_ROUND, "CORDIC missed round")
  `OFDR_ASSERT_NXT(a_done_after_round, state_r == C_ROUND, done_r && state_r == C_IDLE, "CORDIC done not raised")

endmodule

`default_nettype wire
